// ===== hdl/assert_macros.svh =====
// assertion helpers included by the scheduler rtl
// every check is sampled on the rising clock and is off while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// antecedent in one cycle requires the consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/psrrs_pkg.sv =====
// ----------------------------------------------------------------------------
// psrrs_pkg
// Types and codes of the round-robin task slot scheduler.
// ----------------------------------------------------------------------------
package psrrs_pkg;

   localparam int REQ_TYPE_W  = 3;
   localparam int TARGET_W    = 6;
   localparam int RSP_SLOT_W  = 4;

   // request codes, the remaining code is rejected as a bad target
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_SCHEDULE = 3'd0,
      REQ_SPAWN    = 3'd1,
      REQ_REVIVE   = 3'd2,
      REQ_KILL     = 3'd3,
      REQ_AWAKEN   = 3'd4,
      REQ_WAIT     = 3'd5,
      REQ_EXIT     = 3'd6
   } req_code_type;

   typedef enum logic [2:0] {
      ST_FREE     = 3'd0,
      ST_READY    = 3'd1,
      ST_RUNNING  = 3'd2,
      ST_WAITING  = 3'd3,
      ST_ZOMBIE   = 3'd4,
      ST_FINISHED = 3'd5
   } slot_state_type;

   typedef enum logic [1:0] {
      RC_OK         = 2'd0,
      RC_NO_SLOT    = 2'd1,
      RC_BAD_TARGET = 2'd2,
      RC_NO_READY   = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      SCAN_PICK,
      SCAN_FREE,
      SCAN_REVIVE
   } scan_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEMOTE_RD,
      S_DEMOTE,
      S_TGT_RD,
      S_TGT,
      S_SCAN,
      S_DONE
   } seq_state_type;

endpackage

// ===== hdl/psrrs_req_if.sv =====
// ----------------------------------------------------------------------------
// psrrs_req_if
// Request channel of the scheduler: valid/ready plus request code and target.
// ----------------------------------------------------------------------------
interface psrrs_req_if
   import psrrs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [TARGET_W-1:0]   target_slot;

   modport source (output valid, output req_type, output target_slot, input ready);
   modport sink   (input valid, input req_type, input target_slot, output ready);
endinterface

// ===== hdl/psrrs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// psrrs_rsp_if
// Result channel of the scheduler: valid/ready plus status and slot fields.
// ----------------------------------------------------------------------------
interface psrrs_rsp_if
   import psrrs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            status_code;
   logic [RSP_SLOT_W-1:0] chosen_slot;
   logic                  current_valid;
   logic [RSP_SLOT_W-1:0] current_slot_out;

   modport source (output valid, output status_code, output chosen_slot,
                   output current_valid, output current_slot_out, input ready);
   modport sink   (input valid, input status_code, input chosen_slot,
                   input current_valid, input current_slot_out, output ready);
endinterface

// ===== hdl/process_slot_round_robin_scheduler.sv =====
// ----------------------------------------------------------------------------
// process_slot_round_robin_scheduler
// Task slot table with round-robin scheduling, spawn, revive, kill, awaken,
// wait and exit requests. One slot table read port is walked by a sequencer.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      req_type, target_slot
//   rsp_ch    out   valid / ready      status_code, chosen_slot,
//                                      current_valid, current_slot_out
//
// a reject goes from idle straight to done; awaken and kill first read the target
// (tgt_rd, tgt) and a schedule with a current task demotes it (demote_rd, demote)
// before any scan; done registers the result and returns to idle, where ready is high
// the scan reads one table entry per cycle through the single read port
// synchronous reset clears the sequencer, the current task and the slot valid bits
// a stalled result holds the sequencer in done until the output register frees
`include "assert_macros.svh"

module process_slot_round_robin_scheduler
   import psrrs_pkg::*;
#(
   parameter int SLOT_COUNT = 16
) (
   input  logic         clock,
   input  logic         reset,
   psrrs_req_if.sink    req_ch,
   psrrs_rsp_if.source  rsp_ch
);

   localparam int SlotW    = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
   localparam int CntW     = $clog2(SLOT_COUNT + 1);
   localparam int TgtCmpW  = TARGET_W + 1;
   localparam int ExtW     = (SlotW > RSP_SLOT_W) ? SlotW : RSP_SLOT_W;

   // slot table memory with per-slot valid bits
   slot_state_type         slot_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  slot_vld_ff;
   slot_state_type         rd_data_ff;
   logic                   rd_vld_ff;
   slot_state_type         rd_state;
   logic [SlotW-1:0]       rd_addr;
   logic                   we;
   logic [SlotW-1:0]       wr_addr;
   slot_state_type         wr_data;

   seq_state_type          state_ff, state_in;
   logic [REQ_TYPE_W-1:0]  req_code_ff, req_code_in;
   logic [TARGET_W-1:0]    target_ff, target_in;
   scan_mode_type          mode_ff, mode_in;
   logic [SlotW-1:0]       pos_ff, pos_in;
   logic [SlotW-1:0]       pos_d_ff, pos_d_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic                   check_ff, check_in;
   logic [SlotW-1:0]       cur_ff, cur_in;
   logic                   has_cur_ff, has_cur_in;
   status_code_type        rc_ff, rc_in;
   logic                   claimed_ff, claimed_in;
   logic [SlotW-1:0]       claim_ff, claim_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_code_type        rsp_status_ff, rsp_status_in;
   logic [RSP_SLOT_W-1:0]  rsp_chosen_ff, rsp_chosen_in;
   logic                   rsp_cur_valid_ff, rsp_cur_valid_in;
   logic [RSP_SLOT_W-1:0]  rsp_cur_ff, rsp_cur_in;

   logic [SlotW-1:0]       start_pick;
   logic [SlotW-1:0]       pos_next;
   logic [SlotW-1:0]       tgt_idx;
   logic                   tgt_range_bad;
   logic                   tgt_is_cur;
   logic                   hit;
   logic [SlotW-1:0]       cur_shown;
   logic [ExtW-1:0]        cur_ext;
   logic [ExtW-1:0]        chosen_ext;

   assign rd_state      = rd_vld_ff ? rd_data_ff : ST_FREE;
   assign start_pick    = !has_cur_ff ? '0 :
                          (cur_ff == SlotW'(SLOT_COUNT - 1)) ? '0 : SlotW'(cur_ff + 1'b1);
   assign pos_next      = (pos_ff == SlotW'(SLOT_COUNT - 1)) ? '0 : SlotW'(pos_ff + 1'b1);
   assign tgt_idx       = target_ff[SlotW-1:0];
   assign tgt_range_bad = {1'b0, req_ch.target_slot} >= TgtCmpW'(SLOT_COUNT);
   assign tgt_is_cur    = has_cur_ff && (target_ff == TARGET_W'(cur_ff));
   assign cur_shown     = has_cur_ff ? cur_ff : '0;
   assign cur_ext       = ExtW'(cur_shown);
   assign chosen_ext    = claimed_ff ? ExtW'(claim_ff) : cur_ext;

   always_comb begin
      case (mode_ff)
         SCAN_PICK:   hit = (rd_state == ST_READY);
         SCAN_FREE:   hit = (rd_state == ST_FREE);
         SCAN_REVIVE: hit = (rd_state == ST_ZOMBIE) || (rd_state == ST_FINISHED);
         default:     hit = 1'b0;
      endcase
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status_code      = rsp_status_ff;
   assign rsp_ch.chosen_slot      = rsp_chosen_ff;
   assign rsp_ch.current_valid    = rsp_cur_valid_ff;
   assign rsp_ch.current_slot_out = rsp_cur_ff;

   // sequencer: next state, table access and result
   always_comb begin
      state_in         = state_ff;
      req_code_in      = req_code_ff;
      target_in        = target_ff;
      mode_in          = mode_ff;
      pos_in           = pos_ff;
      pos_d_in         = pos_d_ff;
      cnt_in           = cnt_ff;
      check_in         = check_ff;
      cur_in           = cur_ff;
      has_cur_in       = has_cur_ff;
      rc_in            = rc_ff;
      claimed_in       = claimed_ff;
      claim_in         = claim_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_chosen_in    = rsp_chosen_ff;
      rsp_cur_valid_in = rsp_cur_valid_ff;
      rsp_cur_in       = rsp_cur_ff;
      rd_addr          = pos_ff;
      we               = 1'b0;
      wr_addr          = cur_ff;
      wr_data          = ST_READY;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               req_code_in = req_ch.req_type;
               target_in   = req_ch.target_slot;
               claimed_in  = 1'b0;
               rc_in       = RC_OK;
               cnt_in      = '0;
               check_in    = 1'b0;
               mode_in     = SCAN_PICK;
               pos_in      = start_pick;
               unique case (req_ch.req_type) inside
                  REQ_SCHEDULE: begin
                     state_in = has_cur_ff ? S_DEMOTE_RD : S_SCAN;
                  end
                  REQ_SPAWN, REQ_REVIVE: begin
                     mode_in  = (req_ch.req_type == REQ_REVIVE) ? SCAN_REVIVE : SCAN_FREE;
                     pos_in   = '0;
                     state_in = S_SCAN;
                  end
                  REQ_KILL, REQ_AWAKEN: begin
                     if (tgt_range_bad) begin
                        rc_in    = RC_BAD_TARGET;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_TGT_RD;
                     end
                  end
                  REQ_WAIT, REQ_EXIT: begin
                     if (!has_cur_ff) begin
                        rc_in    = RC_BAD_TARGET;
                        state_in = S_DONE;
                     end else begin
                        // current slot leaves running, so no demote is needed
                        we       = 1'b1;
                        wr_addr  = cur_ff;
                        wr_data  = (req_ch.req_type == REQ_WAIT) ? ST_WAITING : ST_FINISHED;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rc_in    = RC_BAD_TARGET;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DEMOTE_RD: begin
            rd_addr  = cur_ff;
            state_in = S_DEMOTE;
         end
         S_DEMOTE: begin
            if (rd_state == ST_RUNNING) begin
               we      = 1'b1;
               wr_addr = cur_ff;
               wr_data = ST_READY;
            end
            state_in = S_SCAN;
         end
         S_TGT_RD: begin
            rd_addr  = tgt_idx;
            state_in = S_TGT;
         end
         S_TGT: begin
            wr_addr = tgt_idx;
            if (req_code_ff == REQ_KILL) begin
               if (rd_state == ST_ZOMBIE || rd_state == ST_FINISHED) begin
                  rc_in    = RC_BAD_TARGET;
                  state_in = S_DONE;
               end else begin
                  we      = 1'b1;
                  wr_data = ST_ZOMBIE;
                  if (tgt_is_cur) begin
                     // killed the running task: reschedule from the next slot
                     mode_in  = SCAN_PICK;
                     pos_in   = start_pick;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else begin
               if (rd_state != ST_WAITING) begin
                  rc_in = RC_BAD_TARGET;
               end else begin
                  we      = 1'b1;
                  wr_data = ST_READY;
               end
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            rd_addr = pos_ff;
            // read data arrives in the cycle after its address, so judge pos_d_ff
            if (check_ff && hit) begin
               we      = 1'b1;
               wr_addr = pos_d_ff;
               rc_in   = RC_OK;
               if (mode_ff == SCAN_PICK) begin
                  wr_data    = ST_RUNNING;
                  cur_in     = pos_d_ff;
                  has_cur_in = 1'b1;
               end else begin
                  wr_data    = ST_READY;
                  claimed_in = 1'b1;
                  claim_in   = pos_d_ff;
               end
               state_in = S_DONE;
            end else if (cnt_ff == CntW'(SLOT_COUNT)) begin
               if (mode_ff == SCAN_PICK) begin
                  has_cur_in = 1'b0;
                  rc_in      = RC_NO_READY;
               end else begin
                  rc_in      = RC_NO_SLOT;
               end
               state_in = S_DONE;
            end else begin
               pos_in   = pos_next;
               pos_d_in = pos_ff;
               cnt_in   = CntW'(cnt_ff + 1'b1);
               check_in = 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = rc_ff;
               rsp_chosen_in    = chosen_ext[RSP_SLOT_W-1:0];
               rsp_cur_valid_in = has_cur_ff;
               rsp_cur_in       = cur_ext[RSP_SLOT_W-1:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
      rd_vld_ff  <= slot_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
      end else if (we) begin
         slot_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         has_cur_ff   <= 1'b0;
         cnt_ff       <= '0;
         check_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         has_cur_ff   <= has_cur_in;
         cnt_ff       <= cnt_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_code_ff      <= req_code_in;
      target_ff        <= target_in;
      mode_ff          <= mode_in;
      pos_ff           <= pos_in;
      pos_d_ff         <= pos_d_in;
      rc_ff            <= rc_in;
      claimed_ff       <= claimed_in;
      claim_ff         <= claim_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_chosen_ff    <= rsp_chosen_in;
      rsp_cur_valid_ff <= rsp_cur_valid_in;
      rsp_cur_ff       <= rsp_cur_in;
   end

   `ASSERT_IMPLIES(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == S_DONE,
                   "result raised outside done")
   `ASSERT_ALWAYS(a_scan_bound, cnt_ff <= CntW'(SLOT_COUNT), "scan counter past slot count")
   `ASSERT_IMPLIES(a_current_running, (state_ff == S_IDLE) && has_cur_ff,
                   slot_vld_ff[cur_ff] && (slot_mem[cur_ff] == ST_RUNNING),
                   "current slot not running while idle")

endmodule
